/* rtl/htrl_pkg.sv */
package htrl_pkg;

	// Default sizes for the top-level parameters.
	localparam int ANGLE_BITS_DEF    = 16;
	localparam int COORD_BITS_DEF    = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	// Coordinate differences are shifted up by this many fraction bits before the CORDIC.
	localparam int GUARD_BITS = 24;

	// Width and reset value of the turn step register.
	localparam int               STEP_BITS  = 15;
	localparam logic [STEP_BITS-1:0] STEP_RESET = 15'd1024;

	// Half a turn in the 32-bit angle accumulator.
	localparam logic [31:0] TURN_HALF = 32'h8000_0000;

	// Side-band flags that travel with each transaction through the CORDIC chain.
	typedef struct packed {
		logic bypass;  // Aim heading comes straight from desired_angle.
		logic zero;    // Target equals position.
	} htrl_mode_t;

	// atan(2^-i) as a fraction of a full turn, scaled by 2^32 and rounded.
	function automatic logic [31:0] htrl_atan(input logic [4:0] idx);
		logic [31:0] val;
		case (idx)
			5'd0:    val = 32'h2000_0000;
			5'd1:    val = 32'h12E4_051E;
			5'd2:    val = 32'h09FB_385B;
			5'd3:    val = 32'h0511_11D4;
			5'd4:    val = 32'h028B_0D43;
			5'd5:    val = 32'h0145_D7E1;
			5'd6:    val = 32'h00A2_F61E;
			5'd7:    val = 32'h0051_7C55;
			5'd8:    val = 32'h0028_BE53;
			5'd9:    val = 32'h0014_5F2F;
			5'd10:   val = 32'h000A_2F98;
			5'd11:   val = 32'h0005_17CC;
			5'd12:   val = 32'h0002_8BE6;
			5'd13:   val = 32'h0001_45F3;
			5'd14:   val = 32'h0000_A2FA;
			5'd15:   val = 32'h0000_517D;
			5'd16:   val = 32'h0000_28BE;
			5'd17:   val = 32'h0000_145F;
			5'd18:   val = 32'h0000_0A30;
			5'd19:   val = 32'h0000_0518;
			5'd20:   val = 32'h0000_028C;
			5'd21:   val = 32'h0000_0146;
			5'd22:   val = 32'h0000_00A3;
			5'd23:   val = 32'h0000_0051;
			5'd24:   val = 32'h0000_0029;
			5'd25:   val = 32'h0000_0014;
			5'd26:   val = 32'h0000_000A;
			5'd27:   val = 32'h0000_0005;
			5'd28:   val = 32'h0000_0003;
			5'd29:   val = 32'h0000_0001;
			5'd30:   val = 32'h0000_0001;
			default: val = 32'h0000_0000;
		endcase
		return val;
	endfunction

endpackage

/* rtl/htrl_if.sv */
// Request channel: one heading query per transaction.
interface htrl_in_if #(
	parameter int ANGLE_BITS = 16,
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic signed [COORD_BITS-1:0] target_x;
	logic signed [COORD_BITS-1:0] target_y;
	logic signed [ANGLE_BITS-1:0] current_angle;
	logic signed [ANGLE_BITS-1:0] desired_angle;

	modport source (
		output valid, func, pos_x, pos_y, target_x, target_y, current_angle, desired_angle,
		input  ready
	);
	modport sink (
		input  valid, func, pos_x, pos_y, target_x, target_y, current_angle, desired_angle,
		output ready
	);
endinterface

// Response channel: one new heading per transaction.
interface htrl_out_if #(
	parameter int ANGLE_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] new_angle;
	logic signed [ANGLE_BITS-1:0] aim_angle;

	modport source (
		output valid, new_angle, aim_angle,
		input  ready
	);
	modport sink (
		input  valid, new_angle, aim_angle,
		output ready
	);
endinterface

/* rtl/htrl_prep.sv */
module htrl_prep #(
	parameter int ANGLE_BITS = htrl_pkg::ANGLE_BITS_DEF,
	parameter int COORD_BITS = htrl_pkg::COORD_BITS_DEF,
	parameter int W          = COORD_BITS + 1 + htrl_pkg::GUARD_BITS + 3,
	parameter int SIDE_W     = 2 * ANGLE_BITS + $bits(htrl_pkg::htrl_mode_t)
) (
	input  logic                clk,
	input  logic                arst_n,
	htrl_in_if.sink             req,
	output logic                dn_valid,
	input  logic                dn_ready,
	output logic signed [W-1:0] dn_x,
	output logic signed [W-1:0] dn_y,
	output logic [31:0]         dn_z,
	output logic [SIDE_W-1:0]   dn_side
);
	import htrl_pkg::*;

	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dy;
	logic signed [W-1:0]        x_ext;
	logic signed [W-1:0]        y_ext;
	logic signed [W-1:0]        x_pre;
	logic signed [W-1:0]        y_pre;
	logic [31:0]                z_pre;
	htrl_mode_t                 mode;
	logic                       en;
	logic                       valid_q;
	logic signed [W-1:0]        x_q;
	logic signed [W-1:0]        y_q;
	logic [31:0]                z_q;
	logic [SIDE_W-1:0]          side_q;

	// Exact differences, scaled up by the guard bits.
	always_comb begin
		dx    = $signed({req.target_x[COORD_BITS-1], req.target_x})
		      - $signed({req.pos_x[COORD_BITS-1], req.pos_x});
		dy    = $signed({req.target_y[COORD_BITS-1], req.target_y})
		      - $signed({req.pos_y[COORD_BITS-1], req.pos_y});
		x_ext = $signed({{(W - COORD_BITS - 1){dx[COORD_BITS]}}, dx}) <<< GUARD_BITS;
		y_ext = $signed({{(W - COORD_BITS - 1){dy[COORD_BITS]}}, dy}) <<< GUARD_BITS;
	end

	// A vector pointing left is turned by half a turn into the right half plane.
	always_comb begin
		if (dx[COORD_BITS]) begin
			x_pre = -x_ext;
			y_pre = -y_ext;
			z_pre = TURN_HALF;
		end else begin
			x_pre = x_ext;
			y_pre = y_ext;
			z_pre = '0;
		end
		mode.bypass = req.func;
		mode.zero   = (dx == '0) && (dy == '0);
	end

	// Input register stage.
	assign en        = !valid_q || dn_ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && req.valid) begin
			x_q    <= x_pre;
			y_q    <= y_pre;
			z_q    <= z_pre;
			side_q <= {mode, req.current_angle, req.desired_angle};
		end
	end

	assign dn_valid = valid_q;
	assign dn_x     = x_q;
	assign dn_y     = y_q;
	assign dn_z     = z_q;
	assign dn_side  = side_q;

endmodule

/* rtl/htrl_cell.sv */
module htrl_cell #(
	parameter int W      = 44,
	parameter int SIDE_W = 34,
	parameter int IDX    = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  logic signed [W-1:0] up_x,
	input  logic signed [W-1:0] up_y,
	input  logic [31:0]         up_z,
	input  logic [SIDE_W-1:0]   up_side,
	output logic                dn_valid,
	input  logic                dn_ready,
	output logic signed [W-1:0] dn_x,
	output logic signed [W-1:0] dn_y,
	output logic [31:0]         dn_z,
	output logic [SIDE_W-1:0]   dn_side
);
	import htrl_pkg::*;

	localparam logic [4:0]  TAB_IDX = 5'(IDX);
	localparam logic [31:0] ATAN_I  = htrl_atan(TAB_IDX);

	logic signed [W-1:0] x_sh;
	logic signed [W-1:0] y_sh;
	logic signed [W-1:0] x_nx;
	logic signed [W-1:0] y_nx;
	logic [31:0]         z_nx;
	logic                en;
	logic                valid_q;
	logic signed [W-1:0] x_q;
	logic signed [W-1:0] y_q;
	logic [31:0]         z_q;
	logic [SIDE_W-1:0]   side_q;

	// One vectoring micro-rotation: drive y toward zero.
	always_comb begin
		x_sh = up_x >>> IDX;
		y_sh = up_y >>> IDX;
		if (!up_y[W-1] && (up_y != '0)) begin
			x_nx = up_x + y_sh;
			y_nx = up_y - x_sh;
			z_nx = up_z + ATAN_I;
		end else begin
			x_nx = up_x - y_sh;
			y_nx = up_y + x_sh;
			z_nx = up_z - ATAN_I;
		end
	end

	// Stage register with its own handshake, so bubbles collapse.
	assign en       = !valid_q || dn_ready;
	assign up_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && up_valid) begin
			x_q    <= x_nx;
			y_q    <= y_nx;
			z_q    <= z_nx;
			side_q <= up_side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_x     = x_q;
	assign dn_y     = y_q;
	assign dn_z     = z_q;
	assign dn_side  = side_q;

`ifndef NO_ASSERTIONS
	// After the pre-rotation, x never drops below zero in any stage.
	a_x_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> !x_q[W-1])
		else $error("CORDIC x went negative");
`endif

endmodule

/* rtl/htrl_limit.sv */
module htrl_limit #(
	parameter int ANGLE_BITS = htrl_pkg::ANGLE_BITS_DEF,
	parameter int SIDE_W     = 2 * ANGLE_BITS + $bits(htrl_pkg::htrl_mode_t)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         up_valid,
	output logic                         up_ready,
	input  logic [31:0]                  up_z,
	input  logic [SIDE_W-1:0]            up_side,
	input  logic [htrl_pkg::STEP_BITS-1:0] max_step,
	htrl_out_if.source                   rsp
);
	import htrl_pkg::*;

	localparam logic [31:0] HALF = 32'((64'd1 << (32 - ANGLE_BITS)) >> 1);
	localparam int LW = ((ANGLE_BITS > STEP_BITS) ? ANGLE_BITS : STEP_BITS) + 2;

	htrl_mode_t                   mode;
	logic [ANGLE_BITS-1:0]        cur;
	logic [ANGLE_BITS-1:0]        des;
	logic [31:0]                  z_rnd;
	logic [ANGLE_BITS-1:0]        aim;
	logic [ANGLE_BITS-1:0]        delta;
	logic                         en1;
	logic                         valid_s1;
	logic [ANGLE_BITS-1:0]        aim_s1;
	logic [ANGLE_BITS-1:0]        cur_s1;
	logic [ANGLE_BITS-1:0]        delta_s1;
	logic signed [LW-1:0]         d_ext;
	logic signed [LW-1:0]         s_ext;
	logic signed [LW-1:0]         clamped;
	logic [ANGLE_BITS-1:0]        new_a;
	logic                         en2;
	logic                         valid_s2;
	logic [ANGLE_BITS-1:0]        new_s2;
	logic [ANGLE_BITS-1:0]        aim_s2;

	// Round the accumulator to the angle width and form the wrapped heading error.
	always_comb begin
		mode  = htrl_mode_t'(up_side[SIDE_W-1 -: $bits(htrl_mode_t)]);
		cur   = up_side[2*ANGLE_BITS-1 -: ANGLE_BITS];
		des   = up_side[ANGLE_BITS-1:0];
		z_rnd = up_z + HALF;
		if (mode.bypass) begin
			aim = des;
		end else if (mode.zero) begin
			aim = '0;
		end else begin
			aim = z_rnd[31 -: ANGLE_BITS];
		end
		delta = aim - cur;
	end

	assign en1      = !valid_s1 || en2;
	assign up_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && up_valid) begin
			aim_s1   <= aim;
			cur_s1   <= cur;
			delta_s1 <= delta;
		end
	end

	// Clamp the error to the turn step and apply it to the current heading.
	always_comb begin
		d_ext = LW'($signed(delta_s1));
		s_ext = $signed({{(LW - STEP_BITS){1'b0}}, max_step});
		if (d_ext > s_ext) begin
			clamped = s_ext;
		end else if (d_ext < -s_ext) begin
			clamped = -s_ext;
		end else begin
			clamped = d_ext;
		end
		new_a = cur_s1 + clamped[ANGLE_BITS-1:0];
	end

	// Output register.
	assign en2 = !valid_s2 || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			new_s2 <= new_a;
			aim_s2 <= aim_s1;
		end
	end

	assign rsp.valid     = valid_s2;
	assign rsp.new_angle = new_s2;
	assign rsp.aim_angle = aim_s2;

`ifndef NO_ASSERTIONS
	// With no heading error the new heading is the aim heading.
	a_zero_err: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && en2 && (delta_s1 == '0)) |=> (rsp.new_angle == rsp.aim_angle))
		else $error("zero error changed the heading");

	// A transaction leaving the first stage always lands in the output register.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && en2) |=> valid_s2)
		else $error("transaction lost between limiter stages");
`endif

endmodule

/* rtl/heading_turn_rate_limiter.sv */
// Pipeline from request to response: one input stage, one cell per CORDIC
// iteration, and two limiter stages.
// Throughput: one transaction per cycle unless rsp.ready is low; every stage
// has its own valid and ready, so empty stages fill while the output waits.
// Reset: arst_n clears all valid flags at once; max_step_q returns to 1024.
module heading_turn_rate_limiter #(
	parameter int ANGLE_BITS    = htrl_pkg::ANGLE_BITS_DEF,
	parameter int COORD_BITS    = htrl_pkg::COORD_BITS_DEF,
	parameter int CORDIC_STAGES = htrl_pkg::CORDIC_STAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [htrl_pkg::STEP_BITS-1:0] cfg_wdata,
	htrl_in_if.sink                        req,
	htrl_out_if.source                     rsp
);
	import htrl_pkg::*;

	localparam int W      = COORD_BITS + 1 + GUARD_BITS + 3;
	localparam int SIDE_W = 2 * ANGLE_BITS + $bits(htrl_mode_t);

	logic [STEP_BITS-1:0] max_step_q;
	logic                 c_valid [0:CORDIC_STAGES];
	logic                 c_ready [0:CORDIC_STAGES];
	logic signed [W-1:0]  c_x     [0:CORDIC_STAGES];
	logic signed [W-1:0]  c_y     [0:CORDIC_STAGES];
	logic [31:0]          c_z     [0:CORDIC_STAGES];
	logic [SIDE_W-1:0]    c_side  [0:CORDIC_STAGES];

	// Turn step register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q <= STEP_RESET;
		end else if (cfg_we) begin
			max_step_q <= cfg_wdata;
		end
	end

	htrl_prep #(
		.ANGLE_BITS (ANGLE_BITS),
		.COORD_BITS (COORD_BITS),
		.W          (W),
		.SIDE_W     (SIDE_W)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.dn_valid (c_valid[0]),
		.dn_ready (c_ready[0]),
		.dn_x     (c_x[0]),
		.dn_y     (c_y[0]),
		.dn_z     (c_z[0]),
		.dn_side  (c_side[0])
	);

	// Chain of CORDIC cells, one iteration each.
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		htrl_cell #(
			.W      (W),
			.SIDE_W (SIDE_W),
			.IDX    (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (c_valid[i]),
			.up_ready (c_ready[i]),
			.up_x     (c_x[i]),
			.up_y     (c_y[i]),
			.up_z     (c_z[i]),
			.up_side  (c_side[i]),
			.dn_valid (c_valid[i+1]),
			.dn_ready (c_ready[i+1]),
			.dn_x     (c_x[i+1]),
			.dn_y     (c_y[i+1]),
			.dn_z     (c_z[i+1]),
			.dn_side  (c_side[i+1])
		);
	end

	htrl_limit #(
		.ANGLE_BITS (ANGLE_BITS),
		.SIDE_W     (SIDE_W)
	) u_limit (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (c_valid[CORDIC_STAGES]),
		.up_ready (c_ready[CORDIC_STAGES]),
		.up_z     (c_z[CORDIC_STAGES]),
		.up_side  (c_side[CORDIC_STAGES]),
		.max_step (max_step_q),
		.rsp      (rsp)
	);

`ifndef NO_ASSERTIONS
	// A configuration write lands in the step register on the next cycle.
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (max_step_q == $past(cfg_wdata)))
		else $error("turn step register write lost");
`endif

endmodule
